>>> design/wpfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window pixel frame buffer writer package
// Panel geometry, store size, operation codes and register indexes.
// ----------------------------------------------------------------------------
package wpfw_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PANEL_PAGES  = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SWAP_XY        = 3'd0;
    localparam cfg_index_t CFG_WINDOW_X_START = 3'd1;
    localparam cfg_index_t CFG_WINDOW_Y_START = 3'd2;
    localparam cfg_index_t CFG_WINDOW_X_END   = 3'd3;
    localparam cfg_index_t CFG_WINDOW_Y_END   = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

endpackage

>>> design/wpfw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module wpfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/window_pixel_framebuffer_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window pixel frame buffer writer
// Monochrome page-organized frame store filled through a drawing window.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream; s_tuser is the operation (push a pixel
// at the cursor or read one stored byte). Every input transfer produces
// exactly one result transfer on the m_ stream: in m_tdata the stored byte for
// a read (zero for a push or an out-of-range read), in m_tuser the clipped flag.
// The cfg channel writes the swap and window registers; it is always ready
// and must be used only while the block is idle, which the block itself does
// not enforce. Writing a window register moves the cursor to the window
// origin. A transfer is accepted every cycle unless the store is being
// cleared or the result side stalls. The result passes the registered read
// of the frame store memory, then the read-modify-write and the output
// register. A byte written by the previous push is forwarded to the next
// access. After reset the store is cleared, one byte per cycle over all
// STORE_BYTES addresses (1024 for the 128 by 64 panel), while s_tready is
// low. When the receiver stalls, the result holds in the output register,
// one more item can enter the memory stage, and then s_tready drops.
// ----------------------------------------------------------------------------
module window_pixel_framebuffer_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // color, read_index, zero fill
    input  logic                            s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // read_data
    output logic                            m_tuser,   // clipped
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wpfw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wpfw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic       swap_xy_reg;
    logic [7:0] win_x_start_reg;
    logic [7:0] win_y_start_reg;
    logic [7:0] win_x_end_reg;
    logic [7:0] win_y_end_reg;
    logic [7:0] cursor_col_reg;
    logic [7:0] cursor_row_reg;
    logic [7:0] cursor_col_next;
    logic [7:0] cursor_row_next;

    logic            clear_active_reg;
    wpfw_pkg::addr_t clear_addr_reg;

    logic            s1_valid_reg;
    logic            s1_op_reg;
    logic            s1_color_reg;
    wpfw_pkg::addr_t s1_addr_reg;
    logic [2:0]      s1_bit_reg;
    logic            s1_clip_reg;
    logic            s1_oor_reg;
    logic            s1_fwd_hit_reg;
    logic [7:0]      s1_fwd_data_reg;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_clip_reg;

    logic            in_op;
    logic            in_color;
    logic [9:0]      in_read_index;
    logic            accept;
    logic            advance;
    logic [7:0]      pix_x;
    logic [7:0]      pix_y;
    logic            pix_clip;
    wpfw_pkg::addr_t pix_addr;
    logic            read_oor;
    wpfw_pkg::addr_t rd_addr;

    logic [7:0]      ram_rdata;
    logic [7:0]      cur_byte;
    logic [7:0]      bit_mask;
    logic [7:0]      new_byte;
    logic            upd_we;
    logic            ram_we;
    wpfw_pkg::addr_t ram_waddr;
    logic [7:0]      ram_wdata;

    assign in_op         = s_tuser;
    assign in_color      = s_tdata[0];
    assign in_read_index = s_tdata[10:1];

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !clear_active_reg && (!s1_valid_reg || advance);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign pix_x    = swap_xy_reg ? cursor_row_reg : cursor_col_reg;
    assign pix_y    = swap_xy_reg ? cursor_col_reg : cursor_row_reg;
    assign pix_clip = (32'(pix_x) >= wpfw_pkg::PANEL_WIDTH)
                   || (32'(pix_y) >= wpfw_pkg::PANEL_HEIGHT);
    assign pix_addr = wpfw_pkg::ADDR_W'(pix_x)
                    + wpfw_pkg::ADDR_W'(pix_y[7:3])
                    * wpfw_pkg::ADDR_W'(wpfw_pkg::PANEL_WIDTH);
    assign read_oor = 32'(in_read_index) >= wpfw_pkg::STORE_BYTES;
    assign rd_addr  = (in_op == wpfw_pkg::OP_READ)
                    ? wpfw_pkg::ADDR_W'(in_read_index) : pix_addr;

    assign cur_byte = s1_fwd_hit_reg ? s1_fwd_data_reg : ram_rdata;
    assign bit_mask = 8'(1) << s1_bit_reg;
    assign new_byte = s1_color_reg ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
    assign upd_we   = s1_valid_reg && advance && (s1_op_reg == wpfw_pkg::OP_PUSH)
                   && !s1_clip_reg;

    assign ram_we    = clear_active_reg || upd_we;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : s1_addr_reg;
    assign ram_wdata = clear_active_reg ? 8'd0 : new_byte;

    wpfw_ram #(
        .WIDTH (8),
        .DEPTH (wpfw_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cursor_col_next = cursor_col_reg + 8'd1;
        cursor_row_next = cursor_row_reg;
        if (cursor_col_next > win_x_end_reg)
        begin
            cursor_col_next = win_x_start_reg;
            cursor_row_next = cursor_row_reg + 8'd1;
            if (cursor_row_next > win_y_end_reg)
            begin
                cursor_row_next = win_y_start_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_xy_reg     <= 1'b0;
            win_x_start_reg <= 8'd0;
            win_y_start_reg <= 8'd0;
            win_x_end_reg   <= 8'd127;
            win_y_end_reg   <= 8'd63;
            cursor_col_reg  <= 8'd0;
            cursor_row_reg  <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wpfw_pkg::CFG_SWAP_XY:
                begin
                    swap_xy_reg <= cfg_data[0];
                end
                wpfw_pkg::CFG_WINDOW_X_START:
                begin
                    win_x_start_reg <= cfg_data;
                    cursor_col_reg  <= cfg_data;
                    cursor_row_reg  <= win_y_start_reg;
                end
                wpfw_pkg::CFG_WINDOW_Y_START:
                begin
                    win_y_start_reg <= cfg_data;
                    cursor_col_reg  <= win_x_start_reg;
                    cursor_row_reg  <= cfg_data;
                end
                wpfw_pkg::CFG_WINDOW_X_END:
                begin
                    win_x_end_reg  <= cfg_data;
                    cursor_col_reg <= win_x_start_reg;
                    cursor_row_reg <= win_y_start_reg;
                end
                wpfw_pkg::CFG_WINDOW_Y_END:
                begin
                    win_y_end_reg  <= cfg_data;
                    cursor_col_reg <= win_x_start_reg;
                    cursor_row_reg <= win_y_start_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && (in_op == wpfw_pkg::OP_PUSH))
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + wpfw_pkg::addr_t'(1);
            if (clear_addr_reg == wpfw_pkg::ADDR_W'(wpfw_pkg::STORE_BYTES - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= in_op;
            s1_color_reg    <= in_color;
            s1_addr_reg     <= rd_addr;
            s1_bit_reg      <= pix_y[2:0];
            s1_clip_reg     <= pix_clip;
            s1_oor_reg      <= read_oor;
            s1_fwd_hit_reg  <= upd_we && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= new_byte;
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= ((s1_op_reg == wpfw_pkg::OP_READ) && !s1_oor_reg)
                          ? cur_byte : 8'd0;
            out_clip_reg <= (s1_op_reg == wpfw_pkg::OP_PUSH) && s1_clip_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

endmodule

>>> design/wpfw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window pixel frame buffer writer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wpfw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("Stalled result changed or was dropped.");

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
        else $error("Clipped push carries nonzero data.");

    a_clear_after_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> !s_tready)
        else $error("Input accepted while the store is being cleared.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_xfer, 2))
        else $error("Result appeared without an input transfer two cycles earlier.");

endmodule

bind window_pixel_framebuffer_writer wpfw_checker u_wpfw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window pixel frame buffer writer testbench
// Drives pixel pushes and byte reads into the frame store through a set of
// drawing windows, predicts every reply with a shadow copy of the store, the
// cursor and the window registers, and compares each result transfer with the
// oldest prediction. Both stream sides idle and stall at random, and one test
// holds off the result side long enough to stall the input side.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } frame_reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    wpfw_pkg::cfg_index_t            cfg_index;
    logic [wpfw_pkg::CFG_DATA_W-1:0] cfg_data;

    logic [7:0] shadow_store [wpfw_pkg::STORE_BYTES];
    logic       shadow_swap;
    logic [7:0] win_x0;
    logic [7:0] win_y0;
    logic [7:0] win_x1;
    logic [7:0] win_y1;
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    logic [9:0] last_plot_byte;

    frame_reply_t replies_due[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned push_count;
    int unsigned read_count;
    int unsigned dropped_count;
    int unsigned window_count;
    int          hold_off_cycles;
    bit          steady_flow;

    window_pixel_framebuffer_writer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic frame_reply_t predict_frame_op(input logic op, input logic color,
                                                      input logic [9:0] ridx);
        frame_reply_t reply;
        logic [7:0]   px;
        logic [7:0]   py;
        int           byte_idx;
        reply = '0;
        if (op == wpfw_pkg::OP_READ)
        begin
            reply.read_data = (ridx < wpfw_pkg::STORE_BYTES) ? shadow_store[ridx] : 8'h00;
            return reply;
        end
        px = shadow_swap ? cur_row : cur_col;
        py = shadow_swap ? cur_col : cur_row;
        if (px >= wpfw_pkg::PANEL_WIDTH || py >= wpfw_pkg::PANEL_HEIGHT)
        begin
            reply.clipped = 1'b1;
        end
        else
        begin
            byte_idx = px + (py >> 3) * wpfw_pkg::PANEL_WIDTH;
            shadow_store[byte_idx][py[2:0]] = color;
            last_plot_byte = byte_idx[9:0];
        end
        cur_col = cur_col + 8'd1;
        if (cur_col > win_x1)
        begin
            cur_col = win_x0;
            cur_row = cur_row + 8'd1;
            if (cur_row > win_y1)
            begin
                cur_row = win_y0;
            end
        end
        return reply;
    endfunction

    function automatic void apply_register(input wpfw_pkg::cfg_index_t idx,
                                           input logic [7:0] value);
        case (idx)
            wpfw_pkg::CFG_SWAP_XY:        shadow_swap = value[0];
            wpfw_pkg::CFG_WINDOW_X_START: win_x0 = value;
            wpfw_pkg::CFG_WINDOW_Y_START: win_y0 = value;
            wpfw_pkg::CFG_WINDOW_X_END:   win_x1 = value;
            wpfw_pkg::CFG_WINDOW_Y_END:   win_y1 = value;
            default:                      ;
        endcase
        if (idx != wpfw_pkg::CFG_SWAP_XY)
        begin
            cur_col = win_x0;
            cur_row = win_y0;
        end
    endfunction

    function automatic int draw_wait();
        if (steady_flow || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_item(input logic op, input logic color, input logic [9:0] ridx);
        int gap;
        frame_reply_t reply;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, ridx, color};
        do @(posedge clk); while (!s_tready);
        reply = predict_frame_op(op, color, ridx);
        replies_due.push_back(reply);
        if (op == wpfw_pkg::OP_READ)
        begin
            read_count++;
        end
        else
        begin
            push_count++;
            if (reply.clipped)
            begin
                dropped_count++;
            end
        end
    endtask

    task automatic push_pixel(input logic color);
        send_item(wpfw_pkg::OP_PUSH, color, 10'($urandom_range(0, 1023)));
    endtask

    task automatic read_byte(input logic [9:0] ridx);
        send_item(wpfw_pkg::OP_READ, 1'($urandom_range(0, 1)), ridx);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input wpfw_pkg::cfg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, value);
    endtask

    task automatic set_window(input logic swap, input logic [7:0] x0, input logic [7:0] y0,
                              input logic [7:0] x1, input logic [7:0] y1);
        wait_idle();
        write_register(wpfw_pkg::CFG_SWAP_XY, {7'b0, swap});
        write_register(wpfw_pkg::CFG_WINDOW_X_START, x0);
        write_register(wpfw_pkg::CFG_WINDOW_Y_START, y0);
        write_register(wpfw_pkg::CFG_WINDOW_X_END, x1);
        write_register(wpfw_pkg::CFG_WINDOW_Y_END, y1);
        cfg_valid <= 1'b0;
        window_count++;
    endtask

    task automatic test_cleared_store();
        read_byte(10'd0);
        read_byte(10'd1023);
    endtask

    task automatic test_set_and_clear();
        // Two-pixel window on one row, so the cursor returns to column zero.
        set_window(1'b0, 8'd0, 8'd0, 8'd1, 8'd0);
        push_pixel(1'b1);
        push_pixel(1'b1);
        push_pixel(1'b0);
        read_byte(10'd0);
        read_byte(10'd1);
    endtask

    task automatic test_swapped_axes();
        set_window(1'b1, 8'd3, 8'd70, 8'd3, 8'd70);
        push_pixel(1'b1);
        set_window(1'b1, 8'd100, 8'd5, 8'd100, 8'd5);
        push_pixel(1'b1);
        read_byte(10'd70);
    endtask

    task automatic test_cursor_overflow();
        // An end of 255 lets the column counter roll over to zero.
        set_window(1'b0, 8'd253, 8'd0, 8'd255, 8'd0);
        repeat (5) push_pixel(1'b1);
        // A start above the end steps the row on every push.
        set_window(1'b0, 8'd9, 8'd62, 8'd4, 8'd255);
        repeat (3) push_pixel(1'b1);
        read_byte(10'd905);
    endtask

    task automatic test_output_backpressure();
        set_window(1'b0, 8'd0, 8'd0, 8'd127, 8'd63);
        steady_flow     = 1'b1;
        hold_off_cycles = 120;
        repeat (60)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                read_byte(last_plot_byte);
            end
            else
            begin
                push_pixel(1'($urandom_range(0, 1)));
            end
        end
        wait_idle();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_windows();
        int          sent;
        int          phase_items;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    x0 = 8'd0;   y0 = 8'd0;   x1 = 8'd127; y1 = 8'd63;
                end
                1, 2:
                begin
                    x0 = 8'($urandom_range(0, 127));
                    y0 = 8'($urandom_range(0, 63));
                    x1 = x0 + 8'($urandom_range(0, 15));
                    y1 = y0 + 8'($urandom_range(0, 15));
                end
                3:
                begin
                    x0 = 8'($urandom_range(1, 255));
                    y0 = 8'($urandom_range(0, 70));
                    x1 = 8'($urandom_range(0, x0 - 1));
                    y1 = 8'($urandom_range(0, 255));
                end
                4:
                begin
                    x0 = 8'd0;   y0 = 8'd0;   x1 = 8'd255; y1 = 8'd255;
                end
                default:
                begin
                    x0 = 8'($urandom_range(0, 255));
                    y0 = 8'($urandom_range(0, 255));
                    x1 = 8'($urandom_range(0, 255));
                    y1 = 8'($urandom_range(0, 255));
                end
            endcase
            set_window(1'($urandom_range(0, 1)), x0, y0, x1, y1);
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(40, 200);
            repeat (phase_items)
            begin
                case ($urandom_range(0, 7))
                    0:       read_byte(10'($urandom_range(0, 1023)));
                    1:       read_byte(last_plot_byte);
                    default: push_pixel(1'($urandom_range(0, 1)));
                endcase
            end
            sent += phase_items;
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        frame_reply_t due;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: unexpected transfer read_data=%h clipped=%b",
                             $realtime, m_tdata, m_tuser);
                end
            end
            else
            begin
                due = replies_due.pop_front();
                if (m_tdata !== due.read_data || m_tuser !== due.clipped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: expected read_data=%h clipped=%b, got read_data=%h clipped=%b",
                                 $realtime, due.read_data, due.clipped, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        int stall;
        int hold;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                hold            = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= wpfw_pkg::OP_PUSH;
        cfg_valid <= 1'b0;
        cfg_index <= wpfw_pkg::CFG_SWAP_XY;
        cfg_data  <= '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        push_count      = 0;
        read_count      = 0;
        dropped_count   = 0;
        window_count    = 0;
        hold_off_cycles = 0;
        steady_flow     = 1'b0;
        last_plot_byte  = '0;
        shadow_swap     = 1'b0;
        win_x0  = 8'd0;
        win_y0  = 8'd0;
        win_x1  = 8'd127;
        win_y1  = 8'd63;
        cur_col = 8'd0;
        cur_row = 8'd0;
        foreach (shadow_store[i])
        begin
            shadow_store[i] = 8'h00;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_store();
        test_set_and_clear();
        test_swapped_axes();
        test_cursor_overflow();
        test_output_backpressure();
        test_random_windows();

        wait_idle();
        repeat (16) @(posedge clk);
        $display("Covered %0d pixel pushes (%0d dropped off the panel) and %0d byte reads",
                 push_count, dropped_count, read_count);
        $display("across %0d window settings, including a long result-side stall.",
                 window_count);
        if (mismatch_count == 0 && replies_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d replies never arrived",
                     mismatch_count, replies_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/wpfw_pkg.sv
design/wpfw_ram.sv
design/window_pixel_framebuffer_writer.sv
design/wpfw_checker.sv
tb/sv/tb.sv
